>>> rtl/cube_face_select_project_defines.svh
// ----------------------------------------------------------------------------
// Cube face select and project: assertion macros
// Shared assertion helpers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CUBE_FACE_SELECT_PROJECT_DEFINES_SVH
`define CUBE_FACE_SELECT_PROJECT_DEFINES_SVH

// Same-cycle implication under the block clock and reset.
`define CFSP_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the block clock and reset.
`define CFSP_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cfsp_pkg.sv
// ----------------------------------------------------------------------------
// Cube face select and project: package
// Widths, codes and pipeline payload types shared by the block's modules.
// ----------------------------------------------------------------------------
package cfsp_pkg;

	// Input component width and quotient fraction bits.
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 14;

	// Output coordinate width, fixed at Q2.14 in 16 bits.
	localparam int UV_BITS = 16;

	// The quotient is resolved over four divider stages.
	localparam int STEPS_PER_STAGE = UV_BITS / 4;

	// Width of the high part of the extended dividend.
	localparam int HI_W = COORD_BITS + FRAC_BITS;

	// Width of the whole extended dividend.
	localparam int WIDE_W = HI_W + UV_BITS;

	// Clamp limits as magnitudes.
	localparam logic [UV_BITS-1:0] UV_MIN_MAG = UV_BITS'(1) << (UV_BITS - 1);
	localparam logic [UV_BITS-1:0] UV_MAX_MAG = UV_MIN_MAG - UV_BITS'(1);

	// Clamp limits as signed output values.
	localparam logic signed [UV_BITS-1:0] UV_MAX = UV_MAX_MAG;
	localparam logic signed [UV_BITS-1:0] UV_MIN = UV_MIN_MAG;

	typedef enum logic [2:0] {
		FACE_PX = 3'd0,
		FACE_PY = 3'd1,
		FACE_PZ = 3'd2,
		FACE_NX = 3'd3,
		FACE_NY = 3'd4,
		FACE_NZ = 3'd5
	} face_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	// Face frame components, one bit wider so that a negated minimum fits.
	typedef struct packed {
		face_t                       face;
		logic signed [COORD_BITS:0]  fu;
		logic signed [COORD_BITS:0]  fv;
		logic signed [COORD_BITS:0]  fw;
	} frame_t;

	// One quotient lane of the restoring divider.
	typedef struct packed {
		logic [COORD_BITS-1:0] rem;
		logic [UV_BITS-1:0]    dvd;
		logic [UV_BITS-1:0]    quo;
		logic                  neg;
		logic                  big;
	} lane_t;

	// Divider state carried from stage to stage.
	typedef struct packed {
		face_t                 face;
		logic                  zero;
		logic [COORD_BITS-1:0] den;
		lane_t                 u;
		lane_t                 v;
	} div_t;

endpackage

>>> rtl/cfsp_in_if.sv
// ----------------------------------------------------------------------------
// Cube face select and project: input channel
// Valid/ready channel carrying one vector and its face request.
// ----------------------------------------------------------------------------
interface cfsp_in_if;

	logic                                 valid;
	logic                                 ready;
	logic signed [cfsp_pkg::COORD_BITS-1:0] coord_x;
	logic signed [cfsp_pkg::COORD_BITS-1:0] coord_y;
	logic signed [cfsp_pkg::COORD_BITS-1:0] coord_z;
	logic                                 use_given_face;
	logic [2:0]                           given_face;

	modport source (
		output valid, coord_x, coord_y, coord_z, use_given_face, given_face,
		input  ready
	);

	modport sink (
		input  valid, coord_x, coord_y, coord_z, use_given_face, given_face,
		output ready
	);

endinterface

>>> rtl/cfsp_out_if.sv
// ----------------------------------------------------------------------------
// Cube face select and project: output channel
// Valid/ready channel carrying the face, the projected u and v and status.
// ----------------------------------------------------------------------------
interface cfsp_out_if;

	logic                              valid;
	logic                              ready;
	logic [2:0]                        face_out;
	logic signed [cfsp_pkg::UV_BITS-1:0] u_out;
	logic signed [cfsp_pkg::UV_BITS-1:0] v_out;
	logic [1:0]                        status;

	modport source (
		output valid, face_out, u_out, v_out, status,
		input  ready
	);

	modport sink (
		input  valid, face_out, u_out, v_out, status,
		output ready
	);

endinterface

>>> rtl/cfsp_face_sel.sv
// ----------------------------------------------------------------------------
// Cube face select and project: face selection
// Picks the dominant or requested face and maps the vector into its frame.
// ----------------------------------------------------------------------------
module cfsp_face_sel (
	input  logic signed [cfsp_pkg::COORD_BITS-1:0] coord_x,
	input  logic signed [cfsp_pkg::COORD_BITS-1:0] coord_y,
	input  logic signed [cfsp_pkg::COORD_BITS-1:0] coord_z,
	input  logic                                   use_given_face,
	input  logic [2:0]                             given_face,
	output cfsp_pkg::frame_t                       frame
);

	// Magnitude of a signed component; the minimum value maps to 2^(n-1).
	function automatic logic [cfsp_pkg::COORD_BITS-1:0] mag_c(
		input logic signed [cfsp_pkg::COORD_BITS-1:0] a
	);
		logic [cfsp_pkg::COORD_BITS-1:0] r;
		r = a;
		return a[cfsp_pkg::COORD_BITS-1] ? (~r + 1'b1) : r;
	endfunction

	logic [cfsp_pkg::COORD_BITS-1:0] ax, ay, az;
	logic signed [cfsp_pkg::COORD_BITS:0] x_e, y_e, z_e;
	cfsp_pkg::face_t dom_face;
	cfsp_pkg::face_t face;
	logic given_ok;

	assign ax = mag_c(coord_x);
	assign ay = mag_c(coord_y);
	assign az = mag_c(coord_z);

	// Dominant face: x wins ties, then y; a zero or negative axis picks the negative face.
	always_comb begin
		if (ax >= ay && ax >= az) begin
			dom_face = (coord_x > 0) ? cfsp_pkg::FACE_PX : cfsp_pkg::FACE_NX;
		end else if (ay >= az) begin
			dom_face = (coord_y > 0) ? cfsp_pkg::FACE_PY : cfsp_pkg::FACE_NY;
		end else begin
			dom_face = (coord_z > 0) ? cfsp_pkg::FACE_PZ : cfsp_pkg::FACE_NZ;
		end
	end

	// A requested face outside the six faces falls back to the dominant one.
	assign given_ok = use_given_face && (given_face <= 3'(cfsp_pkg::FACE_NZ));
	assign face     = given_ok ? cfsp_pkg::face_t'(given_face) : dom_face;

	assign x_e = {coord_x[cfsp_pkg::COORD_BITS-1], coord_x};
	assign y_e = {coord_y[cfsp_pkg::COORD_BITS-1], coord_y};
	assign z_e = {coord_z[cfsp_pkg::COORD_BITS-1], coord_z};

	// Permute and negate the components into the face frame.
	always_comb begin
		frame.face = face;
		case (face)
			cfsp_pkg::FACE_PX: begin
				frame.fu = -z_e; frame.fv = y_e;  frame.fw = x_e;
			end
			cfsp_pkg::FACE_NX: begin
				frame.fu = -z_e; frame.fv = -y_e; frame.fw = x_e;
			end
			cfsp_pkg::FACE_PY: begin
				frame.fu = x_e;  frame.fv = -z_e; frame.fw = y_e;
			end
			cfsp_pkg::FACE_NY: begin
				frame.fu = -x_e; frame.fv = -z_e; frame.fw = y_e;
			end
			cfsp_pkg::FACE_PZ: begin
				frame.fu = x_e;  frame.fv = y_e;  frame.fw = z_e;
			end
			default: begin
				frame.fu = x_e;  frame.fv = -y_e; frame.fw = z_e;
			end
		endcase
	end

endmodule

>>> rtl/cfsp_div_prep.sv
// ----------------------------------------------------------------------------
// Cube face select and project: divider setup
// Takes magnitudes and signs and flags quotients too large for the output.
// ----------------------------------------------------------------------------
module cfsp_div_prep (
	input  cfsp_pkg::frame_t frame,
	output cfsp_pkg::div_t   div_init
);

	// Magnitude of a frame component, which never exceeds 2^(n-1).
	function automatic logic [cfsp_pkg::COORD_BITS-1:0] mag_f(
		input logic signed [cfsp_pkg::COORD_BITS:0] a
	);
		logic [cfsp_pkg::COORD_BITS:0] r;
		r = a;
		r = a[cfsp_pkg::COORD_BITS] ? (~r + 1'b1) : r;
		return r[cfsp_pkg::COORD_BITS-1:0];
	endfunction

	// Build one lane: when the dividend's top part reaches the divisor the
	// quotient has more bits than the output and the lane saturates.
	function automatic cfsp_pkg::lane_t prep_lane(
		input logic signed [cfsp_pkg::COORD_BITS:0] num,
		input logic signed [cfsp_pkg::COORD_BITS:0] den_s,
		input logic [cfsp_pkg::COORD_BITS-1:0]      den
	);
		logic [cfsp_pkg::WIDE_W-1:0] ext;
		logic [cfsp_pkg::HI_W-1:0]   hi;
		cfsp_pkg::lane_t             l;
		ext   = {{cfsp_pkg::UV_BITS{1'b0}}, mag_f(num), {cfsp_pkg::FRAC_BITS{1'b0}}};
		hi    = ext[cfsp_pkg::WIDE_W-1:cfsp_pkg::UV_BITS];
		l.big = hi >= {{cfsp_pkg::FRAC_BITS{1'b0}}, den};
		l.rem = hi[cfsp_pkg::COORD_BITS-1:0];
		l.dvd = ext[cfsp_pkg::UV_BITS-1:0];
		l.quo = '0;
		l.neg = num[cfsp_pkg::COORD_BITS] ^ den_s[cfsp_pkg::COORD_BITS];
		return l;
	endfunction

	logic [cfsp_pkg::COORD_BITS-1:0] den;

	assign den = mag_f(frame.fw);

	always_comb begin
		div_init.face = frame.face;
		div_init.zero = (frame.fw == '0);
		div_init.den  = den;
		div_init.u    = prep_lane(frame.fu, frame.fw, den);
		div_init.v    = prep_lane(frame.fv, frame.fw, den);
	end

endmodule

>>> rtl/cfsp_div_step.sv
// ----------------------------------------------------------------------------
// Cube face select and project: divider step group
// Resolves a group of quotient bits for both lanes by restoring division.
// ----------------------------------------------------------------------------
module cfsp_div_step (
	input  cfsp_pkg::div_t d_in,
	output cfsp_pkg::div_t d_out
);

	// A few restoring steps: shift in a dividend bit, subtract when it fits.
	function automatic cfsp_pkg::lane_t step_lane(
		input cfsp_pkg::lane_t                 l_in,
		input logic [cfsp_pkg::COORD_BITS-1:0] den
	);
		cfsp_pkg::lane_t               l;
		logic [cfsp_pkg::COORD_BITS:0] trial;
		logic                          fits;
		l = l_in;
		for (int i = 0; i < cfsp_pkg::STEPS_PER_STAGE; i++) begin
			trial = {l.rem, l.dvd[cfsp_pkg::UV_BITS-1]};
			fits  = trial >= {1'b0, den};
			if (fits) begin
				trial = trial - {1'b0, den};
			end
			l.rem = trial[cfsp_pkg::COORD_BITS-1:0];
			l.dvd = {l.dvd[cfsp_pkg::UV_BITS-2:0], 1'b0};
			l.quo = {l.quo[cfsp_pkg::UV_BITS-2:0], fits};
		end
		return l;
	endfunction

	always_comb begin
		d_out   = d_in;
		d_out.u = step_lane(d_in.u, d_in.den);
		d_out.v = step_lane(d_in.v, d_in.den);
	end

endmodule

>>> rtl/cube_face_select_project.sv
// ----------------------------------------------------------------------------
// Cube face select and project: top level
// Seven-stage pipeline from vector to face, Q2.14 u and v, and status.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one vector (coord_x, coord_y, coord_z) with use_given_face
//   and given_face; a transfer happens when valid and ready are both high.
//   out_ch carries face_out, u_out, v_out and status, one result for each
//   input transfer, in input order.
//   Each input transfer moves through the stage 1 to 7 registers in order.
//   Throughput is one item per cycle while the receiver does not stall:
//   stage 1 picks the face and frame, stage 2 sets up the divider, stages
//   3 to 6 each resolve four quotient bits of both u and v, and stage 7
//   clamps and holds the result.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ch.ready drops in the same cycle; nothing is lost or repeated.
//   Reset clears every stage valid bit; the pipeline comes up empty and
//   ready.
// ----------------------------------------------------------------------------
`include "cube_face_select_project_defines.svh"

module cube_face_select_project (
	input logic       clk,
	input logic       arst_n,
	cfsp_in_if.sink   in_ch,
	cfsp_out_if.source out_ch
);

	// Clamp a lane's unsigned quotient into the signed output; top bit is the flag.
	function automatic logic [cfsp_pkg::UV_BITS:0] clamp_lane(
		input cfsp_pkg::lane_t l
	);
		logic [cfsp_pkg::UV_BITS-1:0] m;
		logic                         sat;
		logic [cfsp_pkg::UV_BITS-1:0] val;
		m   = l.quo;
		sat = 1'b0;
		if (l.big) begin
			sat = 1'b1;
			m   = l.neg ? cfsp_pkg::UV_MIN_MAG : cfsp_pkg::UV_MAX_MAG;
		end else if (l.neg && m > cfsp_pkg::UV_MIN_MAG) begin
			sat = 1'b1;
			m   = cfsp_pkg::UV_MIN_MAG;
		end else if (!l.neg && m > cfsp_pkg::UV_MAX_MAG) begin
			sat = 1'b1;
			m   = cfsp_pkg::UV_MAX_MAG;
		end
		val = l.neg ? (~m + 1'b1) : m;
		return {sat, val};
	endfunction

	logic en;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	cfsp_pkg::frame_t frame_c, frame_s1;
	cfsp_pkg::div_t   prep_c, prep_s2;
	cfsp_pkg::div_t   div3_c, div4_c, div5_c, div6_c;
	cfsp_pkg::div_t   div_s3, div_s4, div_s5, div_s6;

	logic [cfsp_pkg::UV_BITS:0]          u_cl, v_cl;
	cfsp_pkg::face_t                     face_s7;
	logic signed [cfsp_pkg::UV_BITS-1:0] u_c, v_c, u_s7, v_s7;
	cfsp_pkg::status_t                   status_c, status_s7;

	// The pipeline moves whenever the output stage is empty or its result is taken.
	assign en          = !valid_s7 || out_ch.ready;
	assign in_ch.ready = en;

	cfsp_face_sel u_face_sel (
		.coord_x        (in_ch.coord_x),
		.coord_y        (in_ch.coord_y),
		.coord_z        (in_ch.coord_z),
		.use_given_face (in_ch.use_given_face),
		.given_face     (in_ch.given_face),
		.frame          (frame_c)
	);

	cfsp_div_prep u_div_prep (
		.frame    (frame_s1),
		.div_init (prep_c)
	);

	cfsp_div_step u_div_step3 (.d_in(prep_s2), .d_out(div3_c));
	cfsp_div_step u_div_step4 (.d_in(div_s3),  .d_out(div4_c));
	cfsp_div_step u_div_step5 (.d_in(div_s4),  .d_out(div5_c));
	cfsp_div_step u_div_step6 (.d_in(div_s5),  .d_out(div6_c));

	// Final clamp and status; a zero denominator forces u and v to zero.
	always_comb begin
		u_cl = clamp_lane(div_s6.u);
		v_cl = clamp_lane(div_s6.v);
		if (div_s6.zero) begin
			u_c      = '0;
			v_c      = '0;
			status_c = cfsp_pkg::ST_ZERO;
		end else begin
			u_c      = u_cl[cfsp_pkg::UV_BITS-1:0];
			v_c      = v_cl[cfsp_pkg::UV_BITS-1:0];
			status_c = (u_cl[cfsp_pkg::UV_BITS] || v_cl[cfsp_pkg::UV_BITS]) ?
				cfsp_pkg::ST_SAT : cfsp_pkg::ST_OK;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_ch.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Stage payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			frame_s1  <= frame_c;
			prep_s2   <= prep_c;
			div_s3    <= div3_c;
			div_s4    <= div4_c;
			div_s5    <= div5_c;
			div_s6    <= div6_c;
			face_s7   <= div_s6.face;
			u_s7      <= u_c;
			v_s7      <= v_c;
			status_s7 <= status_c;
		end
	end

	assign out_ch.valid    = valid_s7;
	assign out_ch.face_out = face_s7;
	assign out_ch.u_out    = u_s7;
	assign out_ch.v_out    = v_s7;
	assign out_ch.status   = status_s7;

	// A zero denominator always comes out with u and v cleared.
	`CFSP_ASSERT_NOW(a_zero_clears_uv, out_ch.valid && out_ch.status == cfsp_pkg::ST_ZERO, out_ch.u_out == '0 && out_ch.v_out == '0, "zero denominator with nonzero u or v")

	// A saturated result has at least one coordinate at a clamp limit.
	`CFSP_ASSERT_NOW(a_sat_at_limit, out_ch.valid && out_ch.status == cfsp_pkg::ST_SAT, out_ch.u_out == cfsp_pkg::UV_MAX || out_ch.u_out == cfsp_pkg::UV_MIN || out_ch.v_out == cfsp_pkg::UV_MAX || out_ch.v_out == cfsp_pkg::UV_MIN, "saturation flagged without a clamped coordinate")

	// Only the six faces and three status codes ever leave the block.
	`CFSP_ASSERT_NOW(a_codes_legal, out_ch.valid, out_ch.face_out <= 3'(cfsp_pkg::FACE_NZ) && (out_ch.status == cfsp_pkg::ST_OK || out_ch.status == cfsp_pkg::ST_SAT || out_ch.status == cfsp_pkg::ST_ZERO), "illegal face or status code on output")

	// A stalled output result holds the whole pipeline until it is taken.
	`CFSP_ASSERT_NEXT(a_stall_holds, valid_s6 && valid_s7 && !out_ch.ready, valid_s7 && $stable(div_s6), "pipeline moved while the output stalled")

endmodule
